@@ hdl/u2u8_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types, constants and the code point to UTF-8 encode function for
// the UTF-16BE to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

  localparam int unsigned UnitW   = 16;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CpW     = 21;
  localparam int unsigned HeldW   = 10;
  localparam int unsigned MaxCpB  = 4;   // bytes of one code point
  localparam int unsigned MaxRun  = 6;   // bytes caused by one word
  localparam int unsigned CntW    = 3;

  localparam logic [UnitW-1:0] HighFirst = 16'hD800;
  localparam logic [UnitW-1:0] HighLast  = 16'hDBFF;
  localparam logic [UnitW-1:0] LowFirst  = 16'hDC00;
  localparam logic [UnitW-1:0] LowLast   = 16'hDFFF;
  localparam logic [10:0]      PlaneOne  = 11'd64;  // 0x10000 >> 10

  // Bytes of one code point, lowest index sent first
  typedef struct packed {
    logic [MaxCpB-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              cnt;
  } cp_bytes_t;

  // Bytes of one word, lowest index sent first
  typedef struct packed {
    logic [MaxRun-1:0][ByteW-1:0] bytes;
    logic [CntW-1:0]              cnt;
  } run_t;

  function automatic cp_bytes_t encode_cp(input logic [CpW-1:0] cp);
    cp_bytes_t r;
    r = '0;
    if (cp == '0) begin
      r.cnt = 3'd0;
    end else if (cp < 21'h80) begin
      r.bytes[0] = {1'b0, cp[6:0]};
      r.cnt      = 3'd1;
    end else if (cp < 21'h800) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt      = 3'd2;
    end else if (cp < 21'h10000) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt      = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt      = 3'd4;
    end
    return r;
  endfunction

endpackage

@@ hdl/utf16be_to_utf8_transcoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16be_to_utf8_transcoder
// UTF-16BE code units in, UTF-8 bytes out, with surrogate pairing.
//
//   channel  ports                                    word
//   in       in_valid, in_stall, in_code_unit,         one UTF-16 code unit
//            in_end_of_string
//   out      out_valid, out_stall, out_byte,           one UTF-8 byte
//            out_run_last
//
// A code unit is registered, encoded in one pass into a run of 0 to 6 bytes,
// and the run is shifted out one byte per cycle while out_stall is low; the
// output byte port sets that rate. From input accept, a unit passes through
// the input register and the output buffer register before its first byte.
// Reset (synchronous, rst_n low) empties both registers and drops any held
// surrogate. An output stall holds the current byte and backs up the input.
// ----------------------------------------------------------------------------
module utf16be_to_utf8_transcoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [u2u8_pkg::UnitW-1:0]  in_code_unit,
  input  logic                        in_end_of_string,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [u2u8_pkg::ByteW-1:0]  out_byte,
  output logic                        out_run_last
);
  import u2u8_pkg::*;

  logic             vld_r, vld_nxt;
  logic [UnitW-1:0] unit_r;
  logic             eos_r;
  logic             load_ok, step, in_take;
  run_t             run;

  assign step     = vld_r && load_ok;
  assign in_stall = vld_r && !load_ok;
  assign in_take  = in_valid && !in_stall;

  // Input register
  always_comb begin
    vld_nxt = vld_r;
    if (in_take) begin
      vld_nxt = 1'b1;
    end else if (step) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      unit_r <= in_code_unit;
      eos_r  <= in_end_of_string;
    end
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  u2u8_encoder u_enc (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .unit  (unit_r),
    .eos   (eos_r),
    .run   (run)
  );

  u2u8_outbuf u_buf (
    .clk          (clk),
    .rst_n        (rst_n),
    .load         (step),
    .run          (run),
    .load_ok      (load_ok),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

@@ hdl/u2u8_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_encoder
// Surrogate tracking and byte assembly: turns one registered code unit into
// the full byte run it causes, and keeps the held high surrogate.
// ----------------------------------------------------------------------------
module u2u8_encoder (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic [u2u8_pkg::UnitW-1:0]  unit,
  input  logic                        eos,
  output u2u8_pkg::run_t              run
);
  import u2u8_pkg::*;

  logic             pend_r, pend_nxt;
  logic [HeldW-1:0] held_r, held_nxt;

  logic             is_high, is_low;
  logic [CpW-1:0]   pair_cp;
  cp_bytes_t        pair_enc, unit_enc;
  logic [2:0][ByteW-1:0] flush_bytes;

  assign is_high = (unit >= HighFirst) && (unit <= HighLast);
  assign is_low  = (unit >= LowFirst) && (unit <= LowLast);

  // 0x10000 + (held << 10) + low bits
  assign pair_cp  = {({1'b0, held_r} + PlaneOne), unit[HeldW-1:0]};
  assign pair_enc = encode_cp(pair_cp);
  assign unit_enc = encode_cp({5'd0, unit});

  // Held high surrogate sent alone: 0xD800 | held, always three bytes
  assign flush_bytes[0] = 8'hED;
  assign flush_bytes[1] = {4'b1010, held_r[9:6]};
  assign flush_bytes[2] = {2'b10, held_r[5:0]};

  // Byte run assembly
  always_comb begin
    run = '0;
    if (pend_r && is_low) begin
      run.bytes[3:0] = pair_enc.bytes;
      run.cnt        = pair_enc.cnt;
    end else if (pend_r) begin
      run.bytes[2:0] = flush_bytes;
      if (!(is_high && !eos)) begin
        run.bytes[5:3] = unit_enc.bytes[2:0];
        run.cnt        = 3'd3 + unit_enc.cnt;
      end else begin
        run.cnt = 3'd3;
      end
    end else if (!(is_high && !eos)) begin
      run.bytes[3:0] = unit_enc.bytes;
      run.cnt        = unit_enc.cnt;
    end
  end

  // Surrogate hold state
  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    if (step) begin
      if (is_high && !eos && !(pend_r && is_low)) begin
        pend_nxt = 1'b1;
        held_nxt = unit[HeldW-1:0];
      end else begin
        pend_nxt = 1'b0;
        held_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      held_r <= '0;
    end else begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

@@ hdl/u2u8_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u8_outbuf
// Result register: holds one word's byte run and shifts it out one byte per
// accepted output word, marking the final byte of the run.
// ----------------------------------------------------------------------------
module u2u8_outbuf (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  u2u8_pkg::run_t              run,
  output logic                        load_ok,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [u2u8_pkg::ByteW-1:0]  out_byte,
  output logic                        out_run_last
);
  import u2u8_pkg::*;

  logic [MaxRun-1:0][ByteW-1:0] bytes_r, bytes_nxt;
  logic [CntW-1:0]              cnt_r, cnt_nxt;
  logic                         take;

  assign out_valid    = (cnt_r != '0);
  assign out_byte     = bytes_r[0];
  assign out_run_last = (cnt_r == 3'd1);
  assign take         = out_valid && !out_stall;
  // Free now, or emptied by the byte leaving this cycle
  assign load_ok      = (cnt_r == '0) || (take && (cnt_r == 3'd1));

  // Load or shift
  always_comb begin
    bytes_nxt = bytes_r;
    cnt_nxt   = cnt_r;
    if (load) begin
      bytes_nxt = run.bytes;
      cnt_nxt   = run.cnt;
    end else if (take) begin
      bytes_nxt = {ByteW'(0), bytes_r[MaxRun-1:1]};
      cnt_nxt   = cnt_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
